// ----- hdl/ffha_pkg.sv -----
// Package: shared types, constants and codes for the first-fit heap allocator.
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int ALIGN_BYTES_DEF  = 8;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 21;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_NO_FIT    = 3'd2,
        ST_BAD_ADDR  = 3'd3,
        ST_DOUBLE    = 3'd4,
        ST_NULL      = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        REG_HEAP_BASE = 1'b0,
        REG_HEAP_SIZE = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FORM,
        S_CHECK,
        S_A_RD,
        S_A_WAIT,
        S_A_EVAL,
        S_A_SPLIT,
        S_F_RD,
        S_F_WAIT,
        S_F_EVAL,
        S_F_NRD,
        S_F_NWAIT,
        S_F_NEVAL,
        S_F_WCUR,
        S_F_PRD,
        S_F_PWAIT,
        S_F_PEVAL,
        S_F_MERGE,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic form;
        logic check;
        logic cursor_zero;
        logic rd_cursor;
        logic rd_target;
        logic rd_next;
        logic alloc_take;
        logic alloc_split;
        logic cursor_step;
        logic f_apply;
        logic f_absorb_next;
        logic f_write_cur;
        logic f_merge_prev;
        logic set_status;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic    ready;
        logic    is_free_op;
        status_t pre_status;
        logic    blk_zero;
        logic    cursor_done;
        logic    blk_fits;
        logic    can_split;
        logic    blk_free;
        logic    tgt_start;
        logic    next_ok;
        logic    have_prev;
        logic    prev_free;
    } dp_stat_t;

endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
// Top level: first-fit heap allocator over an address-ordered block table.
// A request rejected up front goes straight to the result; alloc reads each block passed over,
// plus a split step; free also walks the blocks ahead of the freed one (predecessor walk).
// Throughput: one request at a time; the next can be taken in the cycle after the result leaves.
// Reset: asynchronous, clears counters and control; then a clearing pass sweeps every
// entry of the start map, during which no request is taken.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] alloc_size,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] address,
    output logic [20:0] used_bytes,
    output logic [20:0] total_bytes,
    output logic [20:0] free_bytes
);

    logic [31:0] heap_base_reg;
    logic [20:0] heap_size_reg;
    logic        busy, in_fire, out_fire, clear_done;
    ffha_pkg::dp_cmd_t  cmd;
    ffha_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            heap_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ffha_pkg::REG_HEAP_BASE: heap_base_reg <= cfg_data;
                ffha_pkg::REG_HEAP_SIZE: heap_size_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    assign in_stall = busy;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    ffha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .clear_done(clear_done), .stat(stat), .cmd(cmd), .busy(busy),
        .res_valid(out_valid));

    ffha_dp #(
        .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .action(action),
        .alloc_size(alloc_size), .free_address(free_address),
        .heap_base_q(heap_base_reg), .heap_size_q(heap_size_reg),
        .cmd(cmd), .stat(stat), .clear_done(clear_done), .status(status),
        .address(address), .used_bytes(used_bytes), .total_bytes(total_bytes),
        .free_bytes(free_bytes));

endmodule

// ----- hdl/ffha_ram.sv -----
// Generic single-port RAM with registered read.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/ffha_ctrl.sv -----
// Controller state machine for the heap allocator.
module ffha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_fire,
    input  logic                clear_done,
    input  ffha_pkg::dp_stat_t  stat,
    output ffha_pkg::dp_cmd_t   cmd,
    output logic                busy,
    output logic                res_valid
);

    ffha_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.status = ffha_pkg::ST_OK;
        busy = 1'b1;
        res_valid = 1'b0;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                busy = !clear_done;
                if (in_fire)
                begin
                    state_next = ffha_pkg::S_FORM;
                end
            end
            ffha_pkg::S_FORM:
            begin
                cmd.form = 1'b1;
                state_next = ffha_pkg::S_CHECK;
            end
            ffha_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                cmd.cursor_zero = 1'b1;
                if (stat.pre_status != ffha_pkg::ST_OK)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = stat.pre_status;
                    state_next = ffha_pkg::S_DONE;
                end
                else if (stat.is_free_op)
                begin
                    state_next = ffha_pkg::S_F_RD;
                end
                else
                begin
                    state_next = ffha_pkg::S_A_RD;
                end
            end
            ffha_pkg::S_A_RD:
            begin
                if (stat.cursor_done)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ffha_pkg::ST_NO_FIT;
                    state_next = ffha_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_cursor = 1'b1;
                    state_next = ffha_pkg::S_A_WAIT;
                end
            end
            ffha_pkg::S_A_WAIT:
            begin
                cmd.rd_cursor = 1'b1;
                state_next = ffha_pkg::S_A_EVAL;
            end
            ffha_pkg::S_A_EVAL:
            begin
                if (stat.blk_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ffha_pkg::ST_NO_FIT;
                    state_next = ffha_pkg::S_DONE;
                end
                else if (stat.blk_free && stat.blk_fits)
                begin
                    cmd.alloc_take = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = ffha_pkg::ST_OK;
                    state_next = stat.can_split ? ffha_pkg::S_A_SPLIT : ffha_pkg::S_DONE;
                end
                else
                begin
                    cmd.cursor_step = 1'b1;
                    state_next = ffha_pkg::S_A_RD;
                end
            end
            ffha_pkg::S_A_SPLIT:
            begin
                cmd.alloc_split = 1'b1;
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_F_RD:
            begin
                cmd.rd_target = 1'b1;
                state_next = ffha_pkg::S_F_WAIT;
            end
            ffha_pkg::S_F_WAIT:
            begin
                cmd.rd_target = 1'b1;
                state_next = ffha_pkg::S_F_EVAL;
            end
            ffha_pkg::S_F_EVAL:
            begin
                if (!stat.tgt_start)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ffha_pkg::ST_BAD_ADDR;
                    state_next = ffha_pkg::S_DONE;
                end
                else if (stat.blk_free)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ffha_pkg::ST_DOUBLE;
                    state_next = ffha_pkg::S_DONE;
                end
                else
                begin
                    cmd.f_apply = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status = ffha_pkg::ST_OK;
                    state_next = ffha_pkg::S_F_NRD;
                end
            end
            ffha_pkg::S_F_NRD:
            begin
                cmd.rd_next = 1'b1;
                state_next = ffha_pkg::S_F_NWAIT;
            end
            ffha_pkg::S_F_NWAIT:
            begin
                cmd.rd_next = 1'b1;
                state_next = ffha_pkg::S_F_NEVAL;
            end
            ffha_pkg::S_F_NEVAL:
            begin
                if (stat.next_ok)
                begin
                    cmd.f_absorb_next = 1'b1;
                end
                state_next = ffha_pkg::S_F_WCUR;
            end
            ffha_pkg::S_F_WCUR:
            begin
                cmd.f_write_cur = 1'b1;
                state_next = ffha_pkg::S_F_PRD;
            end
            ffha_pkg::S_F_PRD:
            begin
                if (stat.cursor_done)
                begin
                    state_next = ffha_pkg::S_F_MERGE;
                end
                else
                begin
                    cmd.rd_cursor = 1'b1;
                    state_next = ffha_pkg::S_F_PWAIT;
                end
            end
            ffha_pkg::S_F_PWAIT:
            begin
                cmd.rd_cursor = 1'b1;
                state_next = ffha_pkg::S_F_PEVAL;
            end
            ffha_pkg::S_F_PEVAL:
            begin
                if (stat.blk_zero)
                begin
                    state_next = ffha_pkg::S_F_MERGE;
                end
                else
                begin
                    cmd.cursor_step = 1'b1;
                    state_next = ffha_pkg::S_F_PRD;
                end
            end
            ffha_pkg::S_F_MERGE:
            begin
                if (stat.have_prev && stat.prev_free)
                begin
                    cmd.f_merge_prev = 1'b1;
                end
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffha_pkg::S_DONE && !out_fire) |=> state_reg == ffha_pkg::S_DONE)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ffha_pkg::S_IDLE)
        else $error("request accepted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !busy || state_reg == ffha_pkg::S_DONE)
        else $error("result outside done state");

endmodule

// ----- hdl/ffha_dp.sv -----
// Datapath: heap tables, counters, cursor and result registers.
module ffha_dp #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      action,
    input  logic [31:0]               alloc_size,
    input  logic [31:0]               free_address,
    input  logic [31:0]               heap_base_q,
    input  logic [20:0]               heap_size_q,
    input  ffha_pkg::dp_cmd_t         cmd,
    output ffha_pkg::dp_stat_t        stat,
    output logic                      clear_done,
    output logic [2:0]                status,
    output logic [31:0]               address,
    output logic [20:0]               used_bytes,
    output logic [20:0]               total_bytes,
    output logic [20:0]               free_bytes
);

    localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
    localparam int GW       = $clog2(GRANULES);
    localparam int SW       = GW + 1;
    localparam int AL_SH    = $clog2(ALIGN_BYTES);
    localparam int TW       = $clog2(HEAP_BYTES) + 1;
    localparam int MIN_BLK  = HEADER_BYTES + 8;
    localparam int MIN_G    = (MIN_BLK + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int CAP      = (HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES;

    logic             ready_reg;
    logic [TW-1:0]    used_reg, total_reg;
    logic             act_reg;
    logic [31:0]      size_reg, ptr_reg;
    logic [SW-1:0]    ng_reg;
    logic             ng_big_reg;
    logic [SW-1:0]    cur_reg;
    logic [GW-1:0]    tgt_reg;
    logic [SW-1:0]    bs_reg;
    logic [SW-1:0]    prev_reg;
    logic [SW-1:0]    prev_size_reg;
    logic             have_prev_reg, prev_free_reg;
    logic [2:0]       status_reg;
    logic [31:0]      addr_reg;
    logic [GW-1:0]    clr_reg;
    logic             clr_done_reg;

    logic             sm_we, bi_we;
    logic [GW-1:0]    sm_addr, bi_addr;
    logic             sm_wd, sm_rd;
    logic [SW:0]      bi_wd, bi_rd;
    logic             sm_rd_ok;
    logic [SW-1:0]    rd_size;
    logic             rd_free;
    logic [SW-1:0]    tg;

    logic [32:0]      need_w;
    logic [32:0]      need_r;
    logic [31:0]      off_w;
    logic [SW-1:0]    nxt_g;
    logic [SW-1:0]    rem_g;
    logic [SW-1:0]    split_g;

    ffha_ram #(.WIDTH(1), .DEPTH(GRANULES)) u_start_map (
        .clk(clk), .we(sm_we), .addr(sm_addr), .wdata(sm_wd), .rdata(sm_rd));
    ffha_ram #(.WIDTH(SW + 1), .DEPTH(GRANULES)) u_block_info (
        .clk(clk), .we(bi_we), .addr(bi_addr), .wdata(bi_wd), .rdata(bi_rd));

    assign tg      = SW'(total_reg >> AL_SH);
    assign rd_size = bi_rd[SW-1:0];
    assign rd_free = bi_rd[SW];
    assign nxt_g   = SW'(tgt_reg) + bs_reg;
    assign rem_g   = rd_size - ng_reg;
    assign split_g = cur_reg + ng_reg;
    assign need_w  = {1'b0, size_reg} + 33'(HEADER_BYTES);
    assign need_r  = (need_w < 33'(MIN_BLK) ? 33'(MIN_BLK) : need_w) + 33'(ALIGN_BYTES - 1);
    assign off_w   = ptr_reg - 32'(HEADER_BYTES) - heap_base_q;

    function automatic logic [TW-1:0] total_form();
        logic [21:0] t;
        t = ({1'b0, heap_size_q} + 22'(ALIGN_BYTES - 1)) >> AL_SH << AL_SH;
        if (32'(t) > 32'(CAP))
        begin
            return TW'(CAP);
        end
        return TW'(t);
    endfunction

    always_comb
    begin
        sm_we = 1'b0;
        bi_we = 1'b0;
        sm_wd = 1'b0;
        bi_wd = '0;
        sm_addr = cur_reg[GW-1:0];
        bi_addr = cur_reg[GW-1:0];
        if (!clr_done_reg)
        begin
            sm_we = 1'b1;
            sm_addr = clr_reg;
        end
        else if (cmd.form && !ready_reg && heap_size_q >= 21'(MIN_BLK))
        begin
            sm_we = 1'b1;
            bi_we = 1'b1;
            sm_addr = '0;
            bi_addr = '0;
            sm_wd = 1'b1;
            bi_wd = {1'b1, SW'(total_form() >> AL_SH)};
        end
        else if (cmd.rd_target || cmd.f_write_cur)
        begin
            sm_addr = tgt_reg;
            bi_addr = tgt_reg;
            if (cmd.f_write_cur)
            begin
                bi_we = 1'b1;
                bi_wd = {1'b1, bs_reg};
            end
        end
        else if (cmd.rd_next || cmd.f_absorb_next)
        begin
            sm_addr = nxt_g[GW-1:0];
            bi_addr = nxt_g[GW-1:0];
            if (cmd.f_absorb_next)
            begin
                sm_we = 1'b1;
            end
        end
        else if (cmd.alloc_take)
        begin
            bi_we = 1'b1;
            bi_wd = {1'b0, stat.can_split ? ng_reg : rd_size};
        end
        else if (cmd.alloc_split)
        begin
            sm_we = 1'b1;
            bi_we = 1'b1;
            sm_addr = split_g[GW-1:0];
            bi_addr = split_g[GW-1:0];
            sm_wd = 1'b1;
            bi_wd = {1'b1, bs_reg};
        end
        else if (cmd.f_merge_prev)
        begin
            sm_we = 1'b1;
            bi_we = 1'b1;
            sm_addr = tgt_reg;
            bi_addr = prev_reg[GW-1:0];
            bi_wd = {1'b1, prev_size_reg + bs_reg};
        end
    end

    assign sm_rd_ok = sm_rd;

    always_comb
    begin
        stat = '0;
        stat.ready = ready_reg;
        stat.is_free_op = act_reg;
        stat.pre_status = ffha_pkg::ST_OK;
        if (!ready_reg)
        begin
            stat.pre_status = ffha_pkg::ST_NOT_READY;
        end
        else if (!act_reg)
        begin
            if (size_reg > 32'(total_reg))
            begin
                stat.pre_status = ffha_pkg::ST_NO_FIT;
            end
        end
        else if (ptr_reg == 32'd0)
        begin
            stat.pre_status = ffha_pkg::ST_NULL;
        end
        else if (off_w >= 32'(total_reg) || off_w[AL_SH-1:0] != '0)
        begin
            stat.pre_status = ffha_pkg::ST_BAD_ADDR;
        end
        stat.blk_zero    = rd_size == '0;
        stat.cursor_done = act_reg ? (cur_reg >= SW'(tgt_reg)) :
                           (cur_reg >= tg || cur_reg >= SW'(GRANULES));
        stat.blk_fits    = !ng_big_reg && rd_size >= ng_reg;
        stat.can_split   = (32'(rem_g) << AL_SH) >= 32'(MIN_BLK) && rem_g >= SW'(MIN_G)
                           && split_g < SW'(GRANULES);
        stat.blk_free    = rd_free;
        stat.tgt_start   = sm_rd_ok;
        stat.next_ok     = nxt_g < tg && nxt_g < SW'(GRANULES) && sm_rd && rd_free;
        stat.have_prev   = have_prev_reg;
        stat.prev_free   = prev_free_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            used_reg <= '0;
            total_reg <= '0;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            if (!clr_done_reg)
            begin
                clr_reg <= clr_reg + GW'(1);
                if (clr_reg == GW'(GRANULES - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (cmd.form && !ready_reg && heap_size_q >= 21'(MIN_BLK))
            begin
                ready_reg <= 1'b1;
                total_reg <= total_form();
                used_reg <= '0;
            end
            if (cmd.alloc_take)
            begin
                used_reg <= used_reg + (TW'(stat.can_split ? ng_reg : rd_size) << AL_SH);
            end
            if (cmd.f_apply)
            begin
                used_reg <= used_reg - (TW'(rd_size) << AL_SH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= action;
            size_reg <= alloc_size;
            ptr_reg <= free_address;
            addr_reg <= '0;
        end
        if (cmd.check)
        begin
            cur_reg <= '0;
            have_prev_reg <= 1'b0;
            prev_free_reg <= 1'b0;
            tgt_reg <= off_w[AL_SH +: GW];
            ng_reg <= SW'(need_r >> AL_SH);
            ng_big_reg <= (need_r >> AL_SH) > 33'(GRANULES);
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.cursor_step)
        begin
            cur_reg <= cur_reg + rd_size;
            if (act_reg)
            begin
                prev_reg <= cur_reg;
                have_prev_reg <= 1'b1;
                prev_free_reg <= rd_free;
            end
        end
        if (cmd.alloc_take)
        begin
            bs_reg <= rem_g;
            addr_reg <= heap_base_q + (32'(cur_reg) << AL_SH) + 32'(HEADER_BYTES);
        end
        if (cmd.f_apply)
        begin
            bs_reg <= rd_size;
        end
        if (cmd.f_absorb_next)
        begin
            bs_reg <= bs_reg + rd_size;
        end
        if (cmd.f_write_cur && !have_prev_reg)
        begin
            prev_reg <= '0;
        end
        if (cmd.f_merge_prev)
        begin
            bs_reg <= bs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cursor_step && act_reg)
        begin
            prev_size_reg <= rd_size;
        end
    end

    assign clear_done  = clr_done_reg;
    assign status      = status_reg;
    assign address     = addr_reg;
    assign used_bytes  = 21'(used_reg);
    assign total_bytes = 21'(total_reg);
    assign free_bytes  = 21'(total_reg - used_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= total_reg)
        else $error("used exceeds total");
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ready_reg) |-> 1'b0)
        else $error("heap unformed after forming");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.form |-> clr_done_reg)
        else $error("work before clear pass");

endmodule
